FILE: hdl/button_click_classifier_unit_macros.svh
// Assertion macros shared by the checker files of the button click classifier.
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH

// Property checked on every rising clock edge while reset is released.
`define BCC_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define BCC_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/bcc_pkg.sv
// Package with the types, codes and constants of the button click classifier.
`default_nettype none

package bcc_pkg;

    // Fixed sizes.
    localparam int NUM_BTN        = 4;
    localparam int COUNT_BITS_DEF = 16;
    localparam int PERIOD_W       = 10;
    localparam int LONG_W         = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 1;
    localparam int ACTIONS_W      = 7;

    // Opcodes of an input transaction.
    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_COLLECT = 2'd2;

    // Per-button click states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS   = 1'd1;
    localparam logic [PERIOD_W-1:0]    PERIOD_RESET     = 10'd10;
    localparam logic [LONG_W-1:0]      LONG_RESET       = 16'd1000;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]         opcode;
        logic [NUM_BTN-1:0] held;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [1:0]           state_btn0;
        logic [1:0]           state_btn1;
        logic [1:0]           state_btn2;
        logic [1:0]           state_btn3;
        logic [ACTIONS_W-1:0] actions;
    } out_item_t;

    // Control that the top level hands to every lane.
    typedef struct packed {
        logic       step;
        logic [1:0] opcode;
    } lane_ctl_t;

    // Timing configuration seen by every lane.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [LONG_W-1:0]   long_ms;
    } timing_cfg_t;

endpackage

`default_nettype wire

FILE: hdl/bcc_lane.sv
// One button lane: click state and hold counter of a single button.
`default_nettype none

module bcc_lane
    import bcc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire lane_ctl_t   ctl,
    input  wire logic        held,
    input  wire timing_cfg_t timing,
    output logic [1:0]       state_now,
    output logic [1:0]       state_after
);

    localparam int PROD_W = COUNT_BITS + PERIOD_W;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [PROD_W-1:0]     hold_ms;
    logic                  long_reached;

    // Elapsed hold time against the long-press threshold.
    assign hold_ms      = PROD_W'(count_reg) * PROD_W'(timing.period);
    assign long_reached = hold_ms >= {{(PROD_W-LONG_W){1'b0}}, timing.long_ms};

    // Next state of this button for the transaction being accepted.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        if (ctl.step)
        begin
            case (ctl.opcode)
                OP_PRESS:
                begin
                    if (held)
                    begin
                        state_next = ST_WAIT;
                    end
                end
                OP_TICK:
                begin
                    if (state_reg == ST_WAIT)
                    begin
                        if (!held)
                        begin
                            state_next = ST_SHORT;
                            count_next = '0;
                        end
                        else if (long_reached)
                        begin
                            state_next = ST_LONG;
                            count_next = '0;
                        end
                        else if (count_reg != '1)
                        begin
                            count_next = count_reg + COUNT_BITS'(1);
                        end
                    end
                end
                OP_COLLECT:
                begin
                    if (state_reg inside {ST_SHORT, ST_LONG})
                    begin
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign state_now   = state_reg;
    assign state_after = state_next;

endmodule

`default_nettype wire

FILE: hdl/bcc_merge.sv
// Merge stage: builds action flags from the lanes and buffers the results.
`default_nettype none

module bcc_merge
    import bcc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lane_ctl_t                ctl,
    input  wire logic [NUM_BTN-1:0][1:0]  lane_now,
    input  wire logic [NUM_BTN-1:0][1:0]  lane_after,
    input  wire logic                     out_ready,
    output logic                          in_ready,
    output logic                          out_valid,
    output out_item_t                     out_data
);

    logic [ACTIONS_W-1:0] actions;
    out_item_t            result;
    out_item_t            head_reg;
    out_item_t            head_next;
    out_item_t            skid_reg;
    out_item_t            skid_next;
    logic                 head_valid_reg;
    logic                 head_valid_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic                 pop;

    // Action flags from the pending clicks that a collect clears.
    always_comb
    begin
        actions = '0;
        if (ctl.opcode == OP_COLLECT)
        begin
            actions[0] = lane_now[0] inside {ST_SHORT, ST_LONG};
            for (int i = 1; i < NUM_BTN; i++)
            begin
                actions[2*i-1] = lane_now[i] == ST_SHORT;
                actions[2*i]   = lane_now[i] == ST_LONG;
            end
        end
    end

    // Result of the transaction being accepted.
    always_comb
    begin
        result.state_btn0 = lane_after[0];
        result.state_btn1 = lane_after[1];
        result.state_btn2 = lane_after[2];
        result.state_btn3 = lane_after[3];
        result.actions    = actions;
    end

    // Two-entry output buffer: the head drives the port, the skid catches
    // a result that arrives while the head is stalled.
    assign pop      = head_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!head_valid_reg || pop)
        begin
            head_next       = result;
            head_valid_next = ctl.step;
        end
        else if (ctl.step)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    // Buffer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Buffer payload.
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

endmodule

`default_nettype wire

FILE: hdl/button_click_classifier_unit.sv
// Top level of the button click classifier: four button lanes and a merge stage.
//
// Usage: input transactions carry an opcode (press report, check tick,
// collect) and the held bits of four buttons on in_valid/in_ready/in_data.
// Every input transaction yields exactly one output transaction on
// out_valid/out_ready/out_data with the four click states after the step
// and, for a collect, the seven action flags.
// The result is registered in the output buffer's head, or in its skid entry while the head is stalled.
// Throughput: one transaction per cycle while in_ready is high; each lane updates its state and
// hold counter through one counter-by-period multiply.
// A two-entry output buffer keeps accepting while one result waits; when
// both entries are full, in_ready drops until the receiver takes one.
// Configuration: cfg_wr_en writes cfg_wr_data to the register chosen by
// cfg_index (check period, long-press time) with no wait state.
// Reset: all buttons idle, counters zero, period 10 ms, long press 1000 ms,
// output buffer empty.
`default_nettype none

module button_click_classifier_unit
    import bcc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_item_t                   out_data,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    logic [PERIOD_W-1:0]      period_reg;
    logic [LONG_W-1:0]        long_reg;
    timing_cfg_t              timing;
    lane_ctl_t                ctl;
    logic [NUM_BTN-1:0][1:0]  lane_now;
    logic [NUM_BTN-1:0][1:0]  lane_after;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            long_reg   <= LONG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CHECK_PERIOD: period_reg <= cfg_wr_data[PERIOD_W-1:0];
                CFG_LONG_PRESS:   long_reg   <= cfg_wr_data[LONG_W-1:0];
                default:          period_reg <= period_reg;
            endcase
        end
    end

    assign timing.period  = period_reg;
    assign timing.long_ms = long_reg;

    // Lane control for the accepted transaction.
    assign ctl.step   = in_valid && in_ready;
    assign ctl.opcode = in_data.opcode;

    // One lane per button.
    for (genvar g = 0; g < NUM_BTN; g++)
    begin : g_lane
        bcc_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .held        (in_data.held[g]),
            .timing      (timing),
            .state_now   (lane_now[g]),
            .state_after (lane_after[g])
        );
    end

    // Action flags and output buffering.
    bcc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .lane_now   (lane_now),
        .lane_after (lane_after),
        .out_ready  (out_ready),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

FILE: hdl/bcc_checker.sv
// Port-level checker of the button click classifier and its bind statement.
`default_nettype none

`include "button_click_classifier_unit_macros.svh"

module bcc_checker
    import bcc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire in_item_t               in_data,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire out_item_t              out_data,
    input wire logic                   cfg_wr_en,
    input wire logic [CFG_INDEX_W-1:0] cfg_index,
    input wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    // A stalled result transaction holds its payload.
    `BCC_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "output transaction changed while stalled")

    // Backpressure on the input only comes from a waiting result.
    `BCC_ASSERT_RUN(a_ready_cause, !in_ready |-> out_valid, "input stalled with no result waiting")

    // A collect that reports actions leaves no click pending.
    `BCC_ASSERT_RUN(a_collect_clears, out_valid && (out_data.actions != '0) |-> (out_data.state_btn0 != ST_SHORT) && (out_data.state_btn0 != ST_LONG) && (out_data.state_btn1 != ST_SHORT) && (out_data.state_btn1 != ST_LONG) && (out_data.state_btn2 != ST_SHORT) && (out_data.state_btn2 != ST_LONG) && (out_data.state_btn3 != ST_SHORT) && (out_data.state_btn3 != ST_LONG), "pending click left after collect")

    // No result is presented right after reset.
    `BCC_ASSERT_ALL(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (.*);

`default_nettype wire
